// ===== design/hssc_pkg.sv =====
// Shared types and constants of the hop schedule sensing controller.
package hssc_pkg;

  // Fraction bits of the slot start and length values.
  localparam int FRAC_BITS = 16;

  localparam int TICK_W  = 32;
  localparam int RND_W   = 32;
  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam int FREQ_W  = 33;
  localparam int TIME_W  = 32;
  localparam int DIV_W   = 33;
  localparam int CFGI_W  = 3;
  localparam int CFGD_W  = 33;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 200;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  typedef enum logic [CFGI_W-1:0] {
    REG_PERIOD     = 3'd0,
    REG_HOP_PERIOD = 3'd1,
    REG_WINDOW     = 3'd2,
    REG_TUNE_START = 3'd3,
    REG_TUNE_END   = 3'd4,
    REG_MODE       = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_MUL0,
    ST_MUL1,
    ST_CMP,
    ST_FMUL0,
    ST_FMUL1,
    ST_FIN,
    ST_HOPMOD,
    ST_RNDMOD,
    ST_OUT
  } state_t;

  // One classified input item as it waits in the queue.
  typedef struct packed {
    kind_t                kind;
    logic [TICK_W-1:0]    tick;
    logic [RND_W-1:0]     rnd;
    logic [START_W-1:0]   start;
    logic [LEN_W-1:0]     len;
  } cmd_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } rem_req_t;

  // Response of the remainder unit.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } rem_rsp_t;

endpackage

// ===== design/hssc_front.sv =====
// Input side: accepts items, classifies them and queues them for the back end.
module hssc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hssc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  output logic                          q_valid,
  input  logic                          q_ready,
  output hssc_pkg::cmd_t                q_cmd
);
  import hssc_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  // Decode the packed transfer into a command.
  always_comb begin
    cmd_in.kind  = kind_t'(in_tuser);
    cmd_in.tick  = in_tdata[31:0];
    cmd_in.rnd   = in_tdata[63:32];
    cmd_in.start = in_tdata[79:64];
    cmd_in.len   = in_tdata[96:80];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = mem_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Queue pointers and fill count.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd_in;
    end
  end

endmodule

// ===== design/hssc_rem.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
module hssc_rem (
  input  logic                clk,
  input  logic                rst_n,
  input  hssc_pkg::rem_req_t  req,
  output hssc_pkg::rem_rsp_t  rsp
);
  import hssc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;

  // One shift and conditional subtract per cycle.
  always_comb begin
    trial    = {rem_r, dvd_r[DIV_W-1]};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
      end
      rem_nxt = trial[DIV_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    if (req.start) begin
      dsr_r <= req.divisor;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== design/hssc_back.sv =====
// Back end: slot table, schedule scan, sensing frequency steps and result register.
module hssc_back #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  hssc_pkg::cmd_t                  q_cmd,
  input  logic                            cfg_valid,
  input  logic [hssc_pkg::CFGI_W-1:0]     cfg_index,
  input  logic [hssc_pkg::CFGD_W-1:0]     cfg_data,
  output hssc_pkg::rem_req_t              rem_req,
  input  hssc_pkg::rem_rsp_t              rem_rsp,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hssc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import hssc_pkg::*;

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int SW = START_W + LEN_W;

  // Configuration registers.
  logic [31:0]       period_r, hop_r;
  logic [FREQ_W-1:0] win_r, ts_r, te_r;
  logic              mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 32'd1000000;
      hop_r    <= 32'd1000;
      win_r    <= 33'd1000000;
      ts_r     <= '0;
      te_r     <= '1;
      mode_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PERIOD:     period_r <= cfg_data[31:0];
        REG_HOP_PERIOD: hop_r    <= cfg_data[31:0];
        REG_WINDOW:     win_r    <= cfg_data;
        REG_TUNE_START: ts_r     <= cfg_data;
        REG_TUNE_END:   te_r     <= cfg_data;
        REG_MODE:       mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [31:0] p_eff, hop_eff;
  assign p_eff   = (period_r == 32'd0) ? 32'd1 : period_r;
  assign hop_eff = (hop_r == 32'd0) ? 32'd1 : hop_r;

  // Slot table, written at the fill count and read at the scan index.
  logic [SW-1:0] slot_mem [MAX_SLOTS];
  logic [SW-1:0] rd_r;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] off_r, off_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  kind_t             kind_r, kind_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic              rej_r, rej_nxt;
  logic [LEN_W-1:0]  lat_r, lat_nxt;
  logic [LEN_W-1:0]  nst_r, nst_nxt;
  logic [FREQ_W-1:0] ta_r, ta_nxt;
  logic [FREQ_W-1:0] tb_r, tb_nxt;
  logic [FREQ_W-1:0] lo_r, lo_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic [TIME_W-1:0] left_r, left_nxt;
  logic [TIME_W-1:0] jump_r, jump_nxt;
  logic              hit_r, hit_nxt;
  logic [3:0]        sidx_r, sidx_nxt;
  logic              mem_we;
  logic              load_out;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Shared fraction-to-time multiplier.
  logic [LEN_W-1:0]        mul_a;
  logic [LEN_W+31:0]       prod;
  logic [FREQ_W-1:0]       frac_t;
  logic [START_W-1:0]      rd_st;
  logic [LEN_W-1:0]        rd_len;
  logic [LEN_W-1:0]        rd_sum;

  assign rd_st  = rd_r[START_W-1:0];
  assign rd_len = rd_r[SW-1:START_W];
  assign rd_sum = LEN_W'({1'b0, rd_st} + rd_len);
  assign prod   = mul_a * {{LEN_W{1'b0}}, p_eff};
  assign frac_t = prod[FRAC_BITS +: FREQ_W];

  // Sensing time arithmetic.
  logic [TIME_W+1:0] opp, since_w, left_w;
  logic [FREQ_W:0]   half, lo_w, f_lin, hi_w;
  logic [FREQ_W:0]   f_sum;

  always_comb begin
    opp = {2'b0, off_r} + {2'b0, p_eff};
    if ({2'b0, off_r} >= {1'b0, ta_r}) begin
      since_w = {2'b0, off_r} - {1'b0, ta_r};
    end else if (opp >= {1'b0, ta_r}) begin
      since_w = opp - {1'b0, ta_r};
    end else begin
      since_w = '0;
    end
    if ({2'b0, off_r} < {1'b0, tb_r}) begin
      left_w = {1'b0, tb_r} - {2'b0, off_r};
    end else begin
      left_w = {1'b0, tb_r} + {2'b0, p_eff} - {2'b0, off_r};
    end
    half  = {2'b0, win_r[FREQ_W-1:1]};
    lo_w  = {1'b0, ts_r} + half;
    hi_w  = {1'b0, te_r} - half;
    f_lin = {1'b0, freq_r} + {1'b0, win_r};
    if (f_lin < {1'b0, ts_r} || f_lin > {1'b0, te_r}) begin
      f_lin = lo_w;
    end
    f_sum = {1'b0, lo_r} + {1'b0, rem_rsp.rem};
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt = state_r;
    off_nxt   = off_r;
    freq_nxt  = freq_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    kind_nxt  = kind_r;
    rnd_nxt   = rnd_r;
    rej_nxt   = rej_r;
    lat_nxt   = lat_r;
    nst_nxt   = nst_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    lo_nxt    = lo_r;
    since_nxt = since_r;
    left_nxt  = left_r;
    jump_nxt  = jump_r;
    hit_nxt   = hit_r;
    sidx_nxt  = sidx_r;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    q_ready   = 1'b0;
    mul_a     = rd_sum;
    rem_req.start    = 1'b0;
    rem_req.dividend = {1'b0, off_r} + {1'b0, q_cmd.tick};
    rem_req.divisor  = {1'b0, p_eff};

    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          kind_nxt = q_cmd.kind;
          rnd_nxt  = q_cmd.rnd;
          rej_nxt  = 1'b0;
          idx_nxt  = '0;
          lat_nxt  = '0;
          nst_nxt  = LEN_W'(1) << FRAC_BITS;
          if (q_cmd.kind == KIND_TICK) begin
            rem_req.start = 1'b1;
            state_nxt     = ST_MOD;
          end else begin
            if (cnt_r < CW'(MAX_SLOTS)) begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              rej_nxt = 1'b1;
            end
            state_nxt = ST_RD;
          end
        end
      end
      ST_MOD: begin
        if (rem_rsp.done) begin
          off_nxt   = rem_rsp.rem[TIME_W-1:0];
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = ST_FMUL0;
        end else begin
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        mul_a     = {1'b0, rd_st};
        ta_nxt    = frac_t;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        mul_a     = rd_sum;
        tb_nxt    = frac_t;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if ({1'b0, off_r} >= ta_r && {1'b0, off_r} < tb_r) begin
          hit_nxt   = 1'b1;
          sidx_nxt  = 4'(idx_r);
          since_nxt = off_r - ta_r[TIME_W-1:0];
          left_nxt  = (tb_r - {1'b0, off_r} > 33'hFFFFFFFF) ? '1
                      : TIME_W'(tb_r - {1'b0, off_r});
          jump_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          if (rd_sum > lat_r) begin
            lat_nxt = rd_sum;
          end
          if ({1'b0, rd_st} < nst_r) begin
            nst_nxt = {1'b0, rd_st};
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_FMUL0: begin
        mul_a     = lat_r;
        ta_nxt    = frac_t;
        state_nxt = ST_FMUL1;
      end
      ST_FMUL1: begin
        mul_a     = nst_r;
        tb_nxt    = frac_t;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        hit_nxt          = 1'b0;
        sidx_nxt         = '0;
        since_nxt        = since_w[TIME_W-1:0];
        left_nxt         = left_w[TIME_W-1:0];
        rem_req.start    = 1'b1;
        rem_req.dividend = {1'b0, since_w[TIME_W-1:0]};
        rem_req.divisor  = {1'b0, hop_eff};
        state_nxt        = ST_HOPMOD;
      end
      ST_HOPMOD: begin
        if (rem_rsp.done) begin
          jump_nxt  = hop_eff - rem_rsp.rem[TIME_W-1:0];
          lo_nxt    = lo_w[FREQ_W] ? '1 : lo_w[FREQ_W-1:0];
          state_nxt = ST_OUT;
          if (rem_rsp.rem == '0 && kind_r == KIND_TICK) begin
            if (!mode_r) begin
              freq_nxt = f_lin[FREQ_W] ? '1 : f_lin[FREQ_W-1:0];
            end else if (te_r >= half[FREQ_W-1:0] && hi_w > lo_w) begin
              rem_req.start    = 1'b1;
              rem_req.dividend = {1'b0, rnd_r};
              rem_req.divisor  = FREQ_W'(hi_w - lo_w);
              state_nxt        = ST_RNDMOD;
            end else begin
              freq_nxt = lo_w[FREQ_W] ? '1 : lo_w[FREQ_W-1:0];
            end
          end
        end
      end
      ST_RNDMOD: begin
        if (rem_rsp.done) begin
          freq_nxt  = f_sum[FREQ_W] ? '1 : f_sum[FREQ_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      off_r       <= '0;
      freq_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      freq_r      <= freq_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    kind_r  <= kind_nxt;
    rnd_r   <= rnd_nxt;
    rej_r   <= rej_nxt;
    lat_r   <= lat_nxt;
    nst_r   <= nst_nxt;
    ta_r    <= ta_nxt;
    tb_r    <= tb_nxt;
    lo_r    <= lo_nxt;
    since_r <= since_nxt;
    left_r  <= left_nxt;
    jump_r  <= jump_nxt;
    hit_r   <= hit_nxt;
    sidx_r  <= sidx_nxt;
  end

  // Slot table write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[cnt_r[IW-1:0]] <= {q_cmd.len, q_cmd.start};
    end
    rd_r <= slot_mem[idx_r[IW-1:0]];
  end

  // Pack the result fields.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r[0]       <= hit_r;
      out_data_r[4:1]     <= sidx_r;
      out_data_r[36:5]    <= hit_r ? since_r : '0;
      out_data_r[68:37]   <= hit_r ? left_r : '0;
      out_data_r[69]      <= !hit_r;
      out_data_r[102:70]  <= freq_r;
      out_data_r[134:103] <= hit_r ? '0 : since_r;
      out_data_r[166:135] <= hit_r ? '0 : left_r;
      out_data_r[198:167] <= jump_r;
      out_data_r[199]     <= rej_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/hop_schedule_sensing_controller_unit.sv =====
// Top level of the hop schedule sensing controller.
// Each input transfer yields exactly one result transfer. A tick that ends in
// the sensing state scans every stored slot and then takes the sensing steps,
// plus a random frequency step when one is due. A tick that lands in a slot
// stops at that slot without scanning the rest. A slot load does not wrap the
// offset. A result that waits on out_tready holds the sequencer only once the
// next result is ready to be loaded. Processing time is set by the shared
// remainder unit, which retires one quotient bit per cycle for the offset wrap,
// the hop phase and the random placement, and by the slot scan, which reads one
// table entry and runs two fraction-to-time multiplies per slot. A two-entry
// queue sits between the input side and the sequencer, and a result register
// lets the next item start while a result waits.
// Configuration writes are always taken.
module hop_schedule_sensing_controller_unit #(
  parameter int MAX_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tick_us, random_value, slot_start_frac, slot_len_frac, zero fill
  input  logic [hssc_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // in_slot, slot_index, slot_since_us, slot_left_us, sensing,
  // sensing_freq_hz, sensing_since_us, sensing_left_us, next_jump_us,
  // load_rejected
  output logic [hssc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hssc_pkg::CFGI_W-1:0]     cfg_index,
  input  logic [hssc_pkg::CFGD_W-1:0]     cfg_data
);
  import hssc_pkg::*;

  logic     q_valid;
  logic     q_ready;
  cmd_t     q_cmd;
  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  assign cfg_ready = 1'b1;

  hssc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  hssc_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  hssc_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rem_req    (rem_req),
    .rem_rsp    (rem_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
